>>> rtl/ebalu_pkg.sv
package ebalu_pkg;

    localparam logic [4:0] OP_ADD    = 5'd0;
    localparam logic [4:0] OP_ADC    = 5'd1;
    localparam logic [4:0] OP_SUB    = 5'd2;
    localparam logic [4:0] OP_SBC    = 5'd3;
    localparam logic [4:0] OP_AND    = 5'd4;
    localparam logic [4:0] OP_XOR    = 5'd5;
    localparam logic [4:0] OP_OR     = 5'd6;
    localparam logic [4:0] OP_CP     = 5'd7;
    localparam logic [4:0] OP_INC    = 5'd8;
    localparam logic [4:0] OP_DEC    = 5'd9;
    localparam logic [4:0] OP_DAA    = 5'd10;
    localparam logic [4:0] OP_CPL    = 5'd11;
    localparam logic [4:0] OP_SCF    = 5'd12;
    localparam logic [4:0] OP_CCF    = 5'd13;
    localparam logic [4:0] OP_RLCA   = 5'd14;
    localparam logic [4:0] OP_RRCA   = 5'd15;
    localparam logic [4:0] OP_RLA    = 5'd16;
    localparam logic [4:0] OP_RRA    = 5'd17;
    localparam logic [4:0] OP_RLC    = 5'd18;
    localparam logic [4:0] OP_RRC    = 5'd19;
    localparam logic [4:0] OP_RL     = 5'd20;
    localparam logic [4:0] OP_RR     = 5'd21;
    localparam logic [4:0] OP_SLA    = 5'd22;
    localparam logic [4:0] OP_SRA    = 5'd23;
    localparam logic [4:0] OP_SRL    = 5'd24;
    localparam logic [4:0] OP_SWAP   = 5'd25;
    localparam logic [4:0] OP_BIT    = 5'd26;
    localparam logic [4:0] OP_RES    = 5'd27;
    localparam logic [4:0] OP_SET    = 5'd28;
    localparam logic [4:0] OP_ADD16  = 5'd29;
    localparam logic [4:0] OP_ADDSP  = 5'd30;
    localparam logic [4:0] OP_UNUSED = 5'd31;

    typedef struct packed {
        logic [4:0]  req_type;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_number;
        logic        zero_flag_in;
        logic        subtract_flag_in;
        logic        half_carry_flag_in;
        logic        carry_flag_in;
    } t_req;

    typedef struct packed {
        logic [15:0] result_value;
        logic        write_back;
        logic        zero_flag_out;
        logic        subtract_flag_out;
        logic        half_carry_flag_out;
        logic        carry_flag_out;
    } t_rsp;

endpackage

>>> rtl/ebalu_req_if.sv
interface ebalu_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  req_type;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_number;
    logic        zero_flag_in;
    logic        subtract_flag_in;
    logic        half_carry_flag_in;
    logic        carry_flag_in;

    modport source (
        output valid, req_type, operand_a, operand_b, bit_number,
        output zero_flag_in, subtract_flag_in, half_carry_flag_in, carry_flag_in,
        input  ready
    );

    modport sink (
        input  valid, req_type, operand_a, operand_b, bit_number,
        input  zero_flag_in, subtract_flag_in, half_carry_flag_in, carry_flag_in,
        output ready
    );
endinterface

>>> rtl/ebalu_rsp_if.sv
interface ebalu_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_value;
    logic        write_back;
    logic        zero_flag_out;
    logic        subtract_flag_out;
    logic        half_carry_flag_out;
    logic        carry_flag_out;

    modport source (
        output valid, result_value, write_back,
        output zero_flag_out, subtract_flag_out, half_carry_flag_out, carry_flag_out,
        input  ready
    );

    modport sink (
        input  valid, result_value, write_back,
        input  zero_flag_out, subtract_flag_out, half_carry_flag_out, carry_flag_out,
        output ready
    );
endinterface

>>> rtl/ebalu_in_stage.sv
module ebalu_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ebalu_pkg::t_req i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output ebalu_pkg::t_req o_req
);
    import ebalu_pkg::*;

    logic r_vld;
    t_req r_req;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end
endmodule

>>> rtl/ebalu_core.sv
module ebalu_core (
    input  ebalu_pkg::t_req i_req,
    output ebalu_pkg::t_rsp o_rsp
);
    import ebalu_pkg::*;

    localparam logic [3:0] DAA_NIB_MAX = 4'hF - 4'd6;
    localparam logic [4:0] DAA_HI_MAX  = 5'd9;
    localparam logic [8:0] DAA_LO_ADJ  = 9'h006;
    localparam logic [8:0] DAA_HI_ADJ  = 9'h060;
    localparam logic [7:0] DAS_LO_ADJ  = 8'hFA;
    localparam logic [7:0] DAS_HI_ADJ  = 8'hA0;

    logic [4:0]  op;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic [8:0]  add9;
    logic [4:0]  addh5;
    logic [8:0]  sub9;
    logic [4:0]  subh5;
    logic [8:0]  daa_lo;
    logic        daa_hit;
    logic [8:0]  daa_sum;
    logic [7:0]  das_sum;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [4:0]  sph5;
    logic [8:0]  spc9;
    logic [15:0] sp16;
    logic [7:0]  mask;

    logic [7:0]  r8;
    logic [15:0] r16;
    logic        wide;
    logic        wr;
    logic        set_z;
    logic        z;
    logic        n;
    logic        h;
    logic        c;

    assign op = i_req.req_type;
    assign wa = i_req.operand_a;
    assign wb = i_req.operand_b;
    assign a  = wa[7:0];
    assign b  = wb[7:0];

    assign cin   = ((op == OP_ADC) || (op == OP_SBC)) ? i_req.carry_flag_in : 1'b0;
    assign add9  = {1'b0, a} + {1'b0, b} + {8'h00, cin};
    assign addh5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
    assign sub9  = {1'b0, a} - {1'b0, b} - {8'h00, cin};
    assign subh5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cin};

    assign daa_lo  = {1'b0, a} +
                     (((a[3:0] > DAA_NIB_MAX) || i_req.half_carry_flag_in) ? DAA_LO_ADJ : 9'h000);
    assign daa_hit = (daa_lo[8:4] > DAA_HI_MAX) || i_req.carry_flag_in;
    assign daa_sum = daa_lo + (daa_hit ? DAA_HI_ADJ : 9'h000);
    assign das_sum = a + (i_req.half_carry_flag_in ? DAS_LO_ADJ : 8'h00)
                       + (i_req.carry_flag_in ? DAS_HI_ADJ : 8'h00);

    assign sum17 = {1'b0, wa} + {1'b0, wb};
    assign sum13 = {1'b0, wa[11:0]} + {1'b0, wb[11:0]};
    assign sph5  = {1'b0, wa[3:0]} + {1'b0, b[3:0]};
    assign spc9  = {1'b0, wa[7:0]} + {1'b0, b};
    assign sp16  = wa + {{8{b[7]}}, b};

    assign mask = 8'h01 << i_req.bit_number;

    always_comb begin
        r8    = a;
        r16   = 16'h0000;
        wide  = 1'b0;
        wr    = 1'b1;
        set_z = 1'b1;
        z     = i_req.zero_flag_in;
        n     = i_req.subtract_flag_in;
        h     = i_req.half_carry_flag_in;
        c     = i_req.carry_flag_in;
        unique case (op)
            OP_ADD, OP_ADC: begin
                r8 = add9[7:0];
                h  = addh5[4];
                c  = add9[8];
                n  = 1'b0;
            end
            OP_SUB, OP_SBC: begin
                r8 = sub9[7:0];
                h  = subh5[4];
                c  = sub9[8];
                n  = 1'b1;
            end
            OP_CP: begin
                z     = (sub9[7:0] == 8'h00);
                h     = subh5[4];
                c     = sub9[8];
                n     = 1'b1;
                wr    = 1'b0;
                set_z = 1'b0;
            end
            OP_AND: begin
                r8 = a & b;
                n  = 1'b0;
                h  = 1'b1;
                c  = 1'b0;
            end
            OP_XOR: begin
                r8 = a ^ b;
                n  = 1'b0;
                h  = 1'b0;
                c  = 1'b0;
            end
            OP_OR: begin
                r8 = a | b;
                n  = 1'b0;
                h  = 1'b0;
                c  = 1'b0;
            end
            OP_INC: begin
                r8 = a + 8'h01;
                h  = (a[3:0] == 4'hF);
                n  = 1'b0;
            end
            OP_DEC: begin
                r8 = a - 8'h01;
                h  = (a[3:0] == 4'h0);
                n  = 1'b1;
            end
            OP_DAA: begin
                if (i_req.subtract_flag_in) begin
                    r8 = das_sum;
                end else begin
                    r8 = daa_sum[7:0];
                    c  = daa_hit;
                end
                h = 1'b0;
            end
            OP_CPL: begin
                r8    = ~a;
                h     = 1'b1;
                n     = 1'b1;
                set_z = 1'b0;
            end
            OP_SCF: begin
                c     = 1'b1;
                h     = 1'b0;
                n     = 1'b0;
                set_z = 1'b0;
            end
            OP_CCF: begin
                c     = ~i_req.carry_flag_in;
                h     = 1'b0;
                n     = 1'b0;
                set_z = 1'b0;
            end
            OP_RLCA, OP_RLC: begin
                r8 = {a[6:0], a[7]};
                c  = a[7];
            end
            OP_RRCA, OP_RRC: begin
                r8 = {a[0], a[7:1]};
                c  = a[0];
            end
            OP_RLA, OP_RL: begin
                r8 = {a[6:0], i_req.carry_flag_in};
                c  = a[7];
            end
            OP_RRA, OP_RR: begin
                r8 = {i_req.carry_flag_in, a[7:1]};
                c  = a[0];
            end
            OP_SLA: begin
                r8 = {a[6:0], 1'b0};
                c  = a[7];
            end
            OP_SRA: begin
                r8 = {a[7], a[7:1]};
                c  = a[0];
            end
            OP_SRL: begin
                r8 = {1'b0, a[7:1]};
                c  = a[0];
            end
            OP_SWAP: begin
                r8 = {a[3:0], a[7:4]};
                c  = 1'b0;
            end
            OP_BIT: begin
                z     = ((a & mask) == 8'h00);
                n     = 1'b0;
                h     = 1'b1;
                wr    = 1'b0;
                set_z = 1'b0;
            end
            OP_RES: begin
                r8    = a & ~mask;
                set_z = 1'b0;
            end
            OP_SET: begin
                r8    = a | mask;
                set_z = 1'b0;
            end
            OP_ADD16: begin
                wide  = 1'b1;
                r16   = sum17[15:0];
                h     = sum13[12];
                c     = sum17[16];
                n     = 1'b0;
                set_z = 1'b0;
            end
            OP_ADDSP: begin
                wide  = 1'b1;
                r16   = sp16;
                h     = sph5[4];
                c     = spc9[8];
                z     = 1'b0;
                n     = 1'b0;
                set_z = 1'b0;
            end
            default: begin
                r8    = 8'h00;
                wr    = 1'b0;
                set_z = 1'b0;
            end
        endcase
        if (set_z) begin
            z = (r8 == 8'h00);
        end
        if ((op == OP_RLCA) || (op == OP_RRCA) || (op == OP_RLA) || (op == OP_RRA)) begin
            z = 1'b0;
        end
        if ((op >= OP_RLCA) && (op <= OP_SWAP)) begin
            n = 1'b0;
            h = 1'b0;
        end
    end

    assign o_rsp.result_value        = wide ? r16 : {8'h00, r8};
    assign o_rsp.write_back          = wr;
    assign o_rsp.zero_flag_out       = z;
    assign o_rsp.subtract_flag_out   = n;
    assign o_rsp.half_carry_flag_out = h;
    assign o_rsp.carry_flag_out      = c;
endmodule

>>> rtl/ebalu_out_stage.sv
module ebalu_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ebalu_pkg::t_rsp i_rsp,
    output logic            o_valid,
    input  logic            i_ready,
    output ebalu_pkg::t_rsp o_rsp
);
    import ebalu_pkg::*;

    logic r_vld;
    t_rsp r_rsp;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rsp <= i_rsp;
        end
    end
endmodule

>>> rtl/eight_bit_alu_with_flags.sv
// Eight-bit ALU with Z, N, H and C flags. Every request carries an operation code,
// two operands, a bit index and the current flags, and gives exactly one response
// with the result, a write-back enable and the new flags. A request is taken every
// cycle unless the response side stalls; it passes the request register and then the
// result register, between which all of the arithmetic is done in one pass. Ready
// on the request side follows ready on the response side through both registers,
// so a stalled sink holds at most two requests in flight.
module eight_bit_alu_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ebalu_req_if.sink   i_req,
    ebalu_rsp_if.source o_rsp
);
    import ebalu_pkg::*;

    t_req w_req_in;
    t_req w_req;
    t_rsp w_rsp;
    t_rsp w_rsp_out;
    logic w_req_vld;
    logic w_core_rdy;
    logic w_out_vld;

    assign w_req_in.req_type           = i_req.req_type;
    assign w_req_in.operand_a          = i_req.operand_a;
    assign w_req_in.operand_b          = i_req.operand_b;
    assign w_req_in.bit_number         = i_req.bit_number;
    assign w_req_in.zero_flag_in       = i_req.zero_flag_in;
    assign w_req_in.subtract_flag_in   = i_req.subtract_flag_in;
    assign w_req_in.half_carry_flag_in = i_req.half_carry_flag_in;
    assign w_req_in.carry_flag_in      = i_req.carry_flag_in;

    ebalu_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_req   (w_req_in),
        .o_valid (w_req_vld),
        .i_ready (w_core_rdy),
        .o_req   (w_req)
    );

    ebalu_core u_core (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    ebalu_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_req_vld),
        .o_ready (w_core_rdy),
        .i_rsp   (w_rsp),
        .o_valid (w_out_vld),
        .i_ready (o_rsp.ready),
        .o_rsp   (w_rsp_out)
    );

    assign o_rsp.valid               = w_out_vld;
    assign o_rsp.result_value        = w_rsp_out.result_value;
    assign o_rsp.write_back          = w_rsp_out.write_back;
    assign o_rsp.zero_flag_out       = w_rsp_out.zero_flag_out;
    assign o_rsp.subtract_flag_out   = w_rsp_out.subtract_flag_out;
    assign o_rsp.half_carry_flag_out = w_rsp_out.half_carry_flag_out;
    assign o_rsp.carry_flag_out      = w_rsp_out.carry_flag_out;

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp.valid)
        else $error("response valid after reset");

    a_req_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_vld && w_core_rdy) |=> o_rsp.valid)
        else $error("request lost between stages");

    a_narrow_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_vld |-> ((w_rsp.result_value[15:8] == 8'h00) ||
                       (w_req.req_type == OP_ADD16) || (w_req.req_type == OP_ADDSP)))
        else $error("high result byte set on byte operation");

    a_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_vld && !w_rsp.write_back) |->
            ((w_req.req_type == OP_CP) || (w_req.req_type == OP_BIT) ||
             (w_req.req_type == OP_UNUSED)))
        else $error("write-back dropped on writing operation");

    a_acc_rot_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_vld && ((w_req.req_type == OP_RLCA) || (w_req.req_type == OP_RRCA) ||
                       (w_req.req_type == OP_RLA) || (w_req.req_type == OP_RRA)))
            |-> !w_rsp.zero_flag_out)
        else $error("accumulator rotate left Z set");
endmodule
